// ----- hdl/srds_pkg.sv -----
package srds_pkg;

    // Defaults for the top-level parameters
    localparam int POSITION_WIDTH_DEF     = 32;
    localparam int POSITION_FRAC_BITS_DEF = 16;
    localparam int NOISE_FRAC_BITS_DEF    = 12;

    // Fixed field widths
    localparam int STEP_W      = 24;  // drift steps and noise scale
    localparam int UNIFORM_W   = 16;
    localparam int GAUSS_W     = 16;
    localparam int THRESH_W    = 17;
    localparam int CFG_INDEX_W = 3;

    // Register map of the configuration channel
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RING_LENGTH      = 3'd0,
        CFG_APEX_POSITION    = 3'd1,
        CFG_DRIFT_LEFT_STEP  = 3'd2,
        CFG_DRIFT_RIGHT_STEP = 3'd3,
        CFG_NOISE_SCALE      = 3'd4,
        CFG_RESET_THRESHOLD  = 3'd5,
        CFG_START_POSITION   = 3'd6
    } t_cfg_reg;

endpackage

// ----- hdl/sawtooth_reset_diffusion_step.sv -----
// Sawtooth-reset diffusion step. Each input request is one Euler-Maruyama step of a particle on
// a ring of length L: a diffusing particle adds noise_scale * gaussian_draw (rounded to nearest,
// ties upward) and wraps once by L, saturating if the step is longer than L; a uniform draw
// below reset_threshold switches it to the resetting phase and adds the sawtooth drift on that
// step too (-drift_left_step left of the apex, +drift_right_step right of it, none on it). A
// resetting particle adds drift plus noise and returns to diffusing, wrapped, once it reaches
// <= 0 or >= L. A request with tuser set loads start_position in the diffusing phase and skips
// the step. Throughput is one request per clock while the output is not stalled; the result
// passes through the input register, noise multiplier register and result register. The
// particle state is updated as a result enters the output register, so consecutive requests
// see each other's result without stalls. Configuration is written through the cfg channel,
// which is always ready; the user must write it only while no request is in flight, as the
// block does not enforce this. Positions and L, the apex and the start are unsigned with
// POSITION_FRAC_BITS fraction bits; the Gaussian draw is signed with NOISE_FRAC_BITS.
module sawtooth_reset_diffusion_step
    import srds_pkg::*;
#(
    parameter int POSITION_WIDTH     = POSITION_WIDTH_DEF,
    parameter int POSITION_FRAC_BITS = POSITION_FRAC_BITS_DEF,
    parameter int NOISE_FRAC_BITS    = NOISE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]          i_cfg_index,
    input  logic [((POSITION_WIDTH > STEP_W) ? POSITION_WIDTH : STEP_W)-1:0] i_cfg_data,

    // input requests
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [UNIFORM_W+GAUSS_W-1:0]    i_s_axis_tdata,  // uniform_draw, gaussian_draw
    input  logic                            i_s_axis_tuser,  // restart

    // results
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [((POSITION_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,  // position, zero padding
    output logic                            o_m_axis_tuser   // phase_now
);

    localparam int PW     = POSITION_WIDTH;
    localparam int OUT_W  = ((PW + 7) / 8) * 8;
    // signed product of zero-extended scale and Gaussian draw
    localparam int PROD_W = STEP_W + 1 + GAUSS_W;
    localparam int NW     = PROD_W - NOISE_FRAC_BITS;
    localparam int MAX_A  = (PW > STEP_W) ? PW : STEP_W;
    localparam int MAX_W  = (MAX_A > NW) ? MAX_A : NW;
    localparam int SW     = MAX_W + 2;  // x + drift + noise never overflows

    // ---------------- configuration registers ----------------
    logic [PW-1:0]       r_ring_length;
    logic [PW-1:0]       r_apex_position;
    logic [STEP_W-1:0]   r_drift_left_step;
    logic [STEP_W-1:0]   r_drift_right_step;
    logic [STEP_W-1:0]   r_noise_scale;
    logic [THRESH_W-1:0] r_reset_threshold;
    logic [PW-1:0]       r_start_position;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length      <= PW'(1) << POSITION_FRAC_BITS;
            r_apex_position    <= PW'(1) << (POSITION_FRAC_BITS - 1);
            r_drift_left_step  <= '0;
            r_drift_right_step <= '0;
            r_noise_scale      <= '0;
            r_reset_threshold  <= '0;
            r_start_position   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RING_LENGTH:      r_ring_length      <= i_cfg_data[PW-1:0];
                CFG_APEX_POSITION:    r_apex_position    <= i_cfg_data[PW-1:0];
                CFG_DRIFT_LEFT_STEP:  r_drift_left_step  <= i_cfg_data[STEP_W-1:0];
                CFG_DRIFT_RIGHT_STEP: r_drift_right_step <= i_cfg_data[STEP_W-1:0];
                CFG_NOISE_SCALE:      r_noise_scale      <= i_cfg_data[STEP_W-1:0];
                CFG_RESET_THRESHOLD:  r_reset_threshold  <= i_cfg_data[THRESH_W-1:0];
                CFG_START_POSITION:   r_start_position   <= i_cfg_data[PW-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Each stage moves when the next one is empty or moving, so bubbles close up
    // even while a result waits at the output.
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic out_free, s2_free, s1_free;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s2_free         = !r_s2_valid || out_free;
    assign s1_free         = !r_s1_valid || s2_free;
    assign o_s_axis_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free)  r_s1_valid  <= i_s_axis_tvalid;
            if (s2_free)  r_s2_valid  <= r_s1_valid;
            if (out_free) r_out_valid <= r_s2_valid;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [UNIFORM_W-1:0]      r_s1_uniform;
    logic signed [GAUSS_W-1:0] r_s1_gauss;
    logic                      r_s1_restart;

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_uniform <= i_s_axis_tdata[UNIFORM_W-1:0];
            r_s1_gauss   <= i_s_axis_tdata[UNIFORM_W+GAUSS_W-1:UNIFORM_W];
            r_s1_restart <= i_s_axis_tuser;
        end
    end

    // ---------------- stage 2: noise term ----------------
    // Arithmetic shift of product plus half an LSB: round to nearest, ties up.
    logic signed [PROD_W-1:0] noise_prod;
    logic signed [PROD_W-1:0] noise_rnd;
    logic signed [NW-1:0]     r_s2_noise;
    logic [UNIFORM_W-1:0]     r_s2_uniform;
    logic                     r_s2_restart;

    assign noise_prod = $signed({1'b0, r_noise_scale}) * r_s1_gauss;
    assign noise_rnd  = noise_prod + (PROD_W'(1) <<< (NOISE_FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_noise   <= noise_rnd[PROD_W-1:NOISE_FRAC_BITS];
            r_s2_uniform <= r_s1_uniform;
            r_s2_restart <= r_s1_restart;
        end
    end

    // ---------------- stage 3: position update ----------------
    logic [PW-1:0]        r_pos;
    logic                 r_phase;
    logic [PW-1:0]        r_out_pos;
    logic                 r_out_phase;

    logic signed [SW-1:0] x_s, n_s, drift_s, len_s, top_s;
    logic signed [SW-1:0] step_s, wrap_a, wrap_b;
    logic                 start_reset;
    logic [PW-1:0]        n_pos;
    logic                 n_phase;

    always_comb begin
        x_s   = $signed({{(SW-PW){1'b0}}, r_pos});
        n_s   = $signed({{(SW-NW){r_s2_noise[NW-1]}}, r_s2_noise});
        len_s = $signed({{(SW-PW){1'b0}}, r_ring_length});
        top_s = (r_ring_length == '0) ? '0 : len_s - SW'(1);

        // drift judged on the position before the step
        if (r_pos < r_apex_position) begin
            drift_s = -$signed({{(SW-STEP_W){1'b0}}, r_drift_left_step});
        end else if (r_pos > r_apex_position) begin
            drift_s = $signed({{(SW-STEP_W){1'b0}}, r_drift_right_step});
        end else begin
            drift_s = '0;
        end

        start_reset = ({1'b0, r_s2_uniform} < r_reset_threshold);

        // diffusing adds drift only on the step that starts a reset
        if (r_phase || start_reset) begin
            step_s = x_s + drift_s + n_s;
        end else begin
            step_s = x_s + n_s;
        end

        // one wrap by L, then saturate into [0, L-1]
        priority if (step_s < 0) begin
            wrap_a = step_s + len_s;
        end else if (step_s >= len_s) begin
            wrap_a = step_s - len_s;
        end else begin
            wrap_a = step_s;
        end
        priority if (wrap_a < 0) begin
            wrap_b = '0;
        end else if (wrap_a > top_s) begin
            wrap_b = top_s;
        end else begin
            wrap_b = wrap_a;
        end

        if (r_s2_restart) begin
            n_pos   = r_start_position;
            n_phase = 1'b0;
        end else if (!r_phase) begin
            n_pos   = wrap_b[PW-1:0];
            n_phase = start_reset;
        end else if (step_s <= 0 || step_s >= len_s) begin
            // reached an end of the ring: back to diffusing
            n_pos   = wrap_b[PW-1:0];
            n_phase = 1'b0;
        end else begin
            n_pos   = step_s[PW-1:0];
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= 1'b0;
        end else if (r_s2_valid && out_free) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && out_free) begin
            r_out_pos   <= n_pos;
            r_out_phase <= n_phase;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_pos);
    assign o_m_axis_tuser  = r_out_phase;

`ifndef SYNTHESIS
    // a pending result always matches the particle state it left behind
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pos == r_pos && r_out_phase == r_phase))
        else $error("output register out of step with particle state");

    // a restart always lands in the diffusing phase at the start position
    a_restart_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && out_free && r_s2_restart) |=>
            (!r_out_phase && r_out_pos == $past(r_start_position)))
        else $error("restart did not load start position");

    // no noise scale, no noise
    a_zero_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_noise_scale == '0 && $past(r_noise_scale) == '0) |->
            (r_s2_noise == '0))
        else $error("noise term non-zero with zero scale");
`endif

endmodule
